// File: hw/rtl/vtu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Viewport transform unit package
// Shared constants, types and single-precision helper functions.
// ----------------------------------------------------------------------------
package vtu_pkg;

  localparam int unsigned FP_W      = 32;
  localparam int unsigned VIEW_W    = 15;
  localparam int unsigned CFG_AW    = 5;
  localparam int unsigned DIV_STEPS = 26;
  localparam int unsigned RECIP_LAT = DIV_STEPS + 2;
  localparam int unsigned MUL_LAT   = 3;
  localparam int unsigned ADD_LAT   = 5;
  localparam int unsigned TOTAL_LAT = RECIP_LAT + 2 * MUL_LAT + ADD_LAT;

  localparam logic [31:0] FP_ONE  = 32'h3F80_0000;
  localparam logic [31:0] FP_HALF = 32'h3F00_0000;
  localparam logic [31:0] FP_ZERO = 32'h0000_0000;
  localparam logic [31:0] FP_QNAN = 32'h7FC0_0000;

  typedef enum logic [2:0] {
    REG_VIEW_LEFT   = 3'd0,
    REG_VIEW_TOP    = 3'd1,
    REG_VIEW_WIDTH  = 3'd2,
    REG_VIEW_HEIGHT = 3'd3,
    REG_DEPTH_MIN   = 3'd4,
    REG_DEPTH_MAX   = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic [31:0] ox;
    logic [31:0] oy;
    logic [31:0] hw;
    logic [31:0] hh;
    logic [31:0] hd;
    logic [31:0] zmin;
  } vtu_view_t;

  typedef struct packed {
    logic [31:0] screen_x;
    logic [31:0] screen_y;
    logic [31:0] screen_depth;
    logic [31:0] recip_w;
  } vtu_result_t;

  function automatic logic [4:0] lzc27(input logic [26:0] v);
    logic [4:0] n;
    n = 5'd27;
    for (int i = 0; i < 27; i++) begin
      if (v[i]) n = 5'(26 - i);
    end
    return n;
  endfunction

  function automatic logic [26:0] shr_sticky(input logic [26:0] m, input logic [9:0] sh);
    logic [26:0] r;
    logic [26:0] mask;
    logic [4:0]  s5;
    s5 = sh[4:0];
    if (sh >= 10'd27) begin
      r = {26'd0, |m};
    end else begin
      mask = ~({27{1'b1}} << s5);
      r = (m >> s5) | {26'd0, |(m & mask)};
    end
    return r;
  endfunction

  function automatic logic [31:0] round_pack(input logic sgn, input logic signed [9:0] e,
                                             input logic [26:0] m);
    logic        sub;
    logic [9:0]  sh;
    logic [26:0] ms;
    logic        rup;
    logic [24:0] sum;
    logic [9:0]  be;
    logic [31:0] r;
    sub = (e < -10'sd126);
    sh  = 10'(-10'sd126 - e);
    ms  = sub ? shr_sticky(m, sh) : m;
    rup = ms[2] & (ms[1] | ms[0] | ms[3]);
    sum = {1'b0, ms[26:3]} + {24'd0, rup};
    if (sub) begin
      r = {sgn, 7'd0, sum[23], sum[22:0]};
    end else begin
      be = 10'(e) + 10'd127 + {9'd0, sum[24]};
      if (be >= 10'd255) begin
        r = {sgn, 8'hFF, 23'd0};
      end else begin
        r = {sgn, be[7:0], sum[24] ? 23'd0 : sum[22:0]};
      end
    end
    return r;
  endfunction

  // Unbiased exponent and significand with the leading one at bit 23.
  function automatic logic [33:0] unpack_norm(input logic [31:0] x);
    logic [4:0]        lz;
    logic [23:0]       mt;
    logic signed [9:0] ex;
    lz = lzc27({1'b0, x[22:0], 3'd0});
    if (x[30:23] != 8'd0) begin
      mt = {1'b1, x[22:0]};
      ex = $signed({2'd0, x[30:23]}) - 10'sd127;
    end else begin
      mt = {1'b0, x[22:0]} << lz;
      ex = -10'sd126 - $signed({5'd0, lz});
    end
    return {ex, mt};
  endfunction

  function automatic logic fp_is_nan(input logic [31:0] x);
    return (x[30:23] == 8'hFF) && (x[22:0] != 23'd0);
  endfunction

  function automatic logic fp_is_inf(input logic [31:0] x);
    return (x[30:23] == 8'hFF) && (x[22:0] == 23'd0);
  endfunction

  function automatic logic fp_is_zero(input logic [31:0] x);
    return x[30:0] == 31'd0;
  endfunction

  // Exact single-precision value of v / 2 for an unsigned integer v.
  function automatic logic [31:0] int_half(input logic [15:0] v);
    logic [4:0]  lz;
    logic [15:0] nv;
    lz = lzc27({v, 11'd0});
    nv = v << lz;
    if (v == 16'd0) return FP_ZERO;
    return {1'b0, 8'(8'd141 - {3'd0, lz}), nv[14:0], 8'd0};
  endfunction

endpackage

// File: hw/rtl/vtu_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Viewport transform unit channels
// Valid/ready channels for clip-space vertices and screen-space results.
// ----------------------------------------------------------------------------
interface vtu_vertex_if;
  logic        valid;
  logic        ready;
  logic [31:0] clip_x;
  logic [31:0] clip_y;
  logic [31:0] clip_z;
  logic [31:0] clip_w;

  modport source(output valid, clip_x, clip_y, clip_z, clip_w, input ready);
  modport sink(input valid, clip_x, clip_y, clip_z, clip_w, output ready);
endinterface

interface vtu_screen_if;
  logic        valid;
  logic        ready;
  logic [31:0] screen_x;
  logic [31:0] screen_y;
  logic [31:0] screen_depth;
  logic [31:0] recip_w;

  modport source(output valid, screen_x, screen_y, screen_depth, recip_w, input ready);
  modport sink(input valid, screen_x, screen_y, screen_depth, recip_w, output ready);
endinterface

// File: hw/rtl/vtu_delay.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Delay line
// Shift register with a common enable that keeps side data in step with a unit.
// ----------------------------------------------------------------------------
module vtu_delay #(
  parameter int unsigned W     = 1,
  parameter int unsigned DEPTH = 1
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         en,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  logic [W-1:0] tap_r [DEPTH];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DEPTH; i++) tap_r[i] <= '0;
    end else if (en) begin
      tap_r[0] <= d;
      for (int i = 1; i < DEPTH; i++) tap_r[i] <= tap_r[i-1];
    end
  end

  assign q = tap_r[DEPTH-1];

endmodule

// File: hw/rtl/vtu_fp_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Single-precision multiplier
// Three stages: unpack and normalise, significand product, round and pack.
// ----------------------------------------------------------------------------
module vtu_fp_mul import vtu_pkg::*; (
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [31:0] y
);

  logic [33:0]       ua, ub;
  logic              sp_a;
  logic [31:0]       spv_a;
  logic              sgn;

  logic [23:0]       ma_r, mb_r;
  logic signed [9:0] ea_r, eb_r;
  logic              sp1_r, sgn1_r;
  logic [31:0]       spv1_r;

  logic [47:0]       p_r;
  logic signed [9:0] es_r;
  logic              sp2_r, sgn2_r;
  logic [31:0]       spv2_r;

  logic [26:0]       mn;
  logic signed [9:0] en_exp;
  logic [31:0]       y_r;

  always_comb begin
    ua  = unpack_norm(a);
    ub  = unpack_norm(b);
    sgn = a[31] ^ b[31];
    sp_a  = 1'b1;
    spv_a = FP_QNAN;
    if (fp_is_nan(a) || fp_is_nan(b) ||
        (fp_is_inf(a) && fp_is_zero(b)) || (fp_is_zero(a) && fp_is_inf(b))) begin
      spv_a = FP_QNAN;
    end else if (fp_is_inf(a) || fp_is_inf(b)) begin
      spv_a = {sgn, 8'hFF, 23'd0};
    end else if (fp_is_zero(a) || fp_is_zero(b)) begin
      spv_a = {sgn, FP_ZERO[30:0]};
    end else begin
      sp_a = 1'b0;
    end
  end

  always_comb begin
    if (p_r[47]) begin
      mn     = {p_r[47:22], |p_r[21:0]};
      en_exp = es_r + 10'sd1;
    end else begin
      mn     = {p_r[46:21], |p_r[20:0]};
      en_exp = es_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ma_r   <= ua[23:0];
      mb_r   <= ub[23:0];
      ea_r   <= $signed(ua[33:24]);
      eb_r   <= $signed(ub[33:24]);
      sp1_r  <= sp_a;
      spv1_r <= spv_a;
      sgn1_r <= sgn;

      p_r    <= ma_r * mb_r;
      es_r   <= ea_r + eb_r;
      sp2_r  <= sp1_r;
      spv2_r <= spv1_r;
      sgn2_r <= sgn1_r;

      y_r    <= sp2_r ? spv2_r : round_pack(sgn2_r, en_exp, mn);
    end
  end

  assign y = y_r;

endmodule

// File: hw/rtl/vtu_fp_add.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Single-precision adder
// Five stages: compare and swap, align, add, normalise, round and pack.
// ----------------------------------------------------------------------------
module vtu_fp_add import vtu_pkg::*; (
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [31:0] y
);

  logic        swp;
  logic [31:0] big, sml;
  logic [7:0]  be1, se1;
  logic        sp_a;
  logic [31:0] spv_a;

  logic [23:0] mb1_r, ms1_r;
  logic [7:0]  eb1_r, dif1_r;
  logic        sub1_r, sgn1_r, zs1_r, sp1_r;
  logic [31:0] spv1_r;

  logic [23:0] mb2_r;
  logic [26:0] al2_r;
  logic [7:0]  eb2_r;
  logic        sub2_r, sgn2_r, zs2_r, sp2_r;
  logic [31:0] spv2_r;

  logic [27:0] s3_r;
  logic [7:0]  eb3_r;
  logic        sgn3_r, zs3_r, sp3_r;
  logic [31:0] spv3_r;

  logic [4:0]        lz;
  logic signed [9:0] ebu;
  logic [26:0]       mn;
  logic signed [9:0] en_exp;

  logic [26:0]       m4_r;
  logic signed [9:0] e4_r;
  logic              nz4_r, sgn4_r, zs4_r, sp4_r;
  logic [31:0]       spv4_r;

  logic [31:0]       y_r;

  always_comb begin
    swp = b[30:0] > a[30:0];
    big = swp ? b : a;
    sml = swp ? a : b;
    be1 = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
    se1 = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
    sp_a  = 1'b1;
    spv_a = FP_QNAN;
    if (fp_is_nan(a) || fp_is_nan(b) ||
        (fp_is_inf(a) && fp_is_inf(b) && (a[31] != b[31]))) begin
      spv_a = FP_QNAN;
    end else if (fp_is_inf(big)) begin
      spv_a = {big[31], 8'hFF, 23'd0};
    end else begin
      sp_a = 1'b0;
    end
  end

  always_comb begin
    lz  = lzc27(s3_r[26:0]);
    ebu = $signed({2'd0, eb3_r}) - 10'sd127;
    if (s3_r[27]) begin
      mn     = {s3_r[27:2], s3_r[1] | s3_r[0]};
      en_exp = ebu + 10'sd1;
    end else begin
      mn     = s3_r[26:0] << lz;
      en_exp = ebu - $signed({5'd0, lz});
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mb1_r  <= {big[30:23] != 8'd0, big[22:0]};
      ms1_r  <= {sml[30:23] != 8'd0, sml[22:0]};
      eb1_r  <= be1;
      dif1_r <= be1 - se1;
      sub1_r <= a[31] ^ b[31];
      sgn1_r <= big[31];
      zs1_r  <= a[31] & b[31];
      sp1_r  <= sp_a;
      spv1_r <= spv_a;

      mb2_r  <= mb1_r;
      al2_r  <= shr_sticky({ms1_r, 3'd0}, {2'd0, dif1_r});
      eb2_r  <= eb1_r;
      sub2_r <= sub1_r;
      sgn2_r <= sgn1_r;
      zs2_r  <= zs1_r;
      sp2_r  <= sp1_r;
      spv2_r <= spv1_r;

      s3_r   <= sub2_r ? ({1'b0, mb2_r, 3'd0} - {1'b0, al2_r})
                       : ({1'b0, mb2_r, 3'd0} + {1'b0, al2_r});
      eb3_r  <= eb2_r;
      sgn3_r <= sgn2_r;
      zs3_r  <= zs2_r;
      sp3_r  <= sp2_r;
      spv3_r <= spv2_r;

      m4_r   <= mn;
      e4_r   <= en_exp;
      nz4_r  <= s3_r != 28'd0;
      sgn4_r <= sgn3_r;
      zs4_r  <= zs3_r;
      sp4_r  <= sp3_r;
      spv4_r <= spv3_r;

      if (sp4_r) begin
        y_r <= spv4_r;
      end else if (!nz4_r) begin
        y_r <= {zs4_r, FP_ZERO[30:0]};
      end else begin
        y_r <= round_pack(sgn4_r, e4_r, m4_r);
      end
    end
  end

  assign y = y_r;

endmodule

// File: hw/rtl/vtu_recip.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Reciprocal unit
// Correctly rounded 1/w by a restoring division pipeline, one quotient bit per
// stage, with 1.0 returned for a zero w.
// ----------------------------------------------------------------------------
module vtu_recip import vtu_pkg::*; (
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] w,
  output logic [31:0] y
);

  typedef enum logic [1:0] {
    RC_NORM,
    RC_ONE,
    RC_ZERO,
    RC_NAN
  } rc_kind_t;

  logic [33:0]       uw;
  rc_kind_t          kind_a;

  logic [23:0]       m0_r;
  logic signed [9:0] e0_r;
  logic              s0_r;
  rc_kind_t          k0_r;

  logic [24:0]       rem_r [DIV_STEPS];
  logic [25:0]       q_r   [DIV_STEPS];
  logic [23:0]       m_r   [DIV_STEPS];
  logic signed [9:0] e_r   [DIV_STEPS];
  logic              s_r   [DIV_STEPS];
  rc_kind_t          k_r   [DIV_STEPS];

  logic [24:0]       rq;
  logic [25:0]       qq;
  logic [26:0]       mn;
  logic signed [9:0] en_exp;
  logic [31:0]       y_r;

  always_comb begin
    uw = unpack_norm(w);
    if (fp_is_nan(w)) begin
      kind_a = RC_NAN;
    end else if (fp_is_zero(w)) begin
      kind_a = RC_ONE;
    end else if (fp_is_inf(w)) begin
      kind_a = RC_ZERO;
    end else begin
      kind_a = RC_NORM;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m0_r <= uw[23:0];
      e0_r <= $signed(uw[33:24]);
      s0_r <= w[31];
      k0_r <= kind_a;
    end
  end

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
    logic [24:0]       rin;
    logic [25:0]       qin;
    logic [23:0]       min;
    logic signed [9:0] ein;
    logic              sin;
    rc_kind_t          kin;
    logic              ge;
    logic [24:0]       rdf;

    if (k == 0) begin : g_first
      assign rin = 25'd1 << 23;
      assign qin = '0;
      assign min = m0_r;
      assign ein = e0_r;
      assign sin = s0_r;
      assign kin = k0_r;
    end else begin : g_next
      assign rin = rem_r[k-1];
      assign qin = q_r[k-1];
      assign min = m_r[k-1];
      assign ein = e_r[k-1];
      assign sin = s_r[k-1];
      assign kin = k_r[k-1];
    end

    assign ge  = rin >= {1'b0, min};
    assign rdf = ge ? (rin - {1'b0, min}) : rin;

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= {rdf[23:0], 1'b0};
        q_r[k]   <= {qin[24:0], ge};
        m_r[k]   <= min;
        e_r[k]   <= ein;
        s_r[k]   <= sin;
        k_r[k]   <= kin;
      end
    end
  end

  always_comb begin
    rq = rem_r[DIV_STEPS-1];
    qq = q_r[DIV_STEPS-1];
    if (qq[25]) begin
      mn     = {qq, rq != 25'd0};
      en_exp = -e_r[DIV_STEPS-1];
    end else begin
      mn     = {qq[24:0], 1'b0, rq != 25'd0};
      en_exp = -e_r[DIV_STEPS-1] - 10'sd1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      case (k_r[DIV_STEPS-1])
        RC_NAN:  y_r <= FP_QNAN;
        RC_ONE:  y_r <= FP_ONE;
        RC_ZERO: y_r <= {s_r[DIV_STEPS-1], FP_ZERO[30:0]};
        default: y_r <= round_pack(s_r[DIV_STEPS-1], en_exp, mn);
      endcase
    end
  end

  assign y = y_r;

endmodule

// File: hw/rtl/vtu_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Viewport transform unit register file
// APB-style register port and the scale and offset constants derived from it.
// ----------------------------------------------------------------------------
module vtu_cfg import vtu_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output vtu_view_t         view
);

  logic [VIEW_W-1:0] left_r, top_r, width_r, height_r;
  logic [31:0]       zmin_r, zmax_r;
  logic [31:0]       ox_r, oy_r, hw_r, hh_r;
  logic [31:0]       zdif, hd;
  logic [2:0]        idx;
  logic              wr;

  assign idx    = paddr[CFG_AW-1:2];
  assign wr     = psel & penable & pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r   <= '0;
      top_r    <= '0;
      width_r  <= '0;
      height_r <= '0;
      zmin_r   <= FP_ZERO;
      zmax_r   <= FP_ONE;
    end else if (wr) begin
      case (idx)
        REG_VIEW_LEFT:   left_r   <= pwdata[VIEW_W-1:0];
        REG_VIEW_TOP:    top_r    <= pwdata[VIEW_W-1:0];
        REG_VIEW_WIDTH:  width_r  <= pwdata[VIEW_W-1:0];
        REG_VIEW_HEIGHT: height_r <= pwdata[VIEW_W-1:0];
        REG_DEPTH_MIN:   zmin_r   <= pwdata;
        REG_DEPTH_MAX:   zmax_r   <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_VIEW_LEFT:   prdata = {17'd0, left_r};
      REG_VIEW_TOP:    prdata = {17'd0, top_r};
      REG_VIEW_WIDTH:  prdata = {17'd0, width_r};
      REG_VIEW_HEIGHT: prdata = {17'd0, height_r};
      REG_DEPTH_MIN:   prdata = zmin_r;
      REG_DEPTH_MAX:   prdata = zmax_r;
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    ox_r <= int_half({1'b0, left_r} + {1'b0, width_r});
    oy_r <= int_half({1'b0, top_r} + {1'b0, height_r});
    hw_r <= int_half({1'b0, width_r});
    hh_r <= int_half({1'b0, height_r});
  end

  vtu_fp_add u_zdif (
    .clk (clk),
    .en  (1'b1),
    .a   (zmax_r),
    .b   ({~zmin_r[31], zmin_r[30:0]}),
    .y   (zdif)
  );

  vtu_fp_mul u_zhalf (
    .clk (clk),
    .en  (1'b1),
    .a   (zdif),
    .b   (FP_HALF),
    .y   (hd)
  );

  assign view.ox   = ox_r;
  assign view.oy   = oy_r;
  assign view.hw   = hw_r;
  assign view.hh   = hh_r;
  assign view.hd   = hd;
  assign view.zmin = zmin_r;

endmodule

// File: hw/rtl/vtu_out_buf.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Output buffer
// Two-word queue that parts the pipeline from the result channel.
// ----------------------------------------------------------------------------
module vtu_out_buf import vtu_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_vld,
  input  vtu_result_t in_data,
  output logic        in_rdy,
  output logic        out_vld,
  input  logic        out_rdy,
  output vtu_result_t out_data
);

  vtu_result_t mem_r [2];
  logic [1:0]  count_r, count_nxt;
  logic        wp_r, rp_r;
  logic        push, pop;

  assign in_rdy   = count_r != 2'd2;
  assign out_vld  = count_r != 2'd0;
  assign push     = in_vld & in_rdy;
  assign pop      = out_vld & out_rdy;
  assign out_data = mem_r[rp_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (pop && !push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      wp_r    <= 1'b0;
      rp_r    <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= in_data;
  end

endmodule

// File: hw/rtl/viewport_transform_unit_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Viewport transform unit
// Perspective divide and viewport mapping of clip-space vertices.
// ----------------------------------------------------------------------------
// The unit takes one vertex per cycle while its input is ready and returns each
// result in order, after a path through the reciprocal, whose 26-stage
// restoring divider produces one quotient bit per stage, then two multiplier
// passes and an adder. A two-word output queue holds finished results; the
// input is ready whenever that queue is not full, so the whole pipeline stalls
// once the queue fills while the result channel is blocked. Registers must be
// written only while the unit is idle; the block itself does not enforce this.
module viewport_transform_unit_top import vtu_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  vtu_vertex_if.sink        in_vtx,
  vtu_screen_if.source      out_scr,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  vtu_view_t   view;
  logic        en;
  logic        vld_last;
  logic [31:0] inv_w, inv_w_d;
  logic [95:0] xyz_d;
  logic [31:0] px, py, pz;
  logic [31:0] tx, ty, tz;
  vtu_result_t res, res_out;

  vtu_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .view    (view)
  );

  assign in_vtx.ready = en;

  vtu_delay #(.W(1), .DEPTH(TOTAL_LAT)) u_vld_dly (
    .clk (clk), .rst_n (rst_n), .en (en), .d (in_vtx.valid), .q (vld_last)
  );

  vtu_recip u_rcp (.clk (clk), .en (en), .w (in_vtx.clip_w), .y (inv_w));

  vtu_delay #(.W(96), .DEPTH(RECIP_LAT)) u_xyz_dly (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .d     ({in_vtx.clip_x, in_vtx.clip_y, in_vtx.clip_z}),
    .q     (xyz_d)
  );

  vtu_delay #(.W(32), .DEPTH(2 * MUL_LAT + ADD_LAT)) u_inv_dly (
    .clk (clk), .rst_n (rst_n), .en (en), .d (inv_w), .q (inv_w_d)
  );

  vtu_fp_mul u_px (.clk (clk), .en (en), .a (xyz_d[95:64]), .b (inv_w), .y (px));
  vtu_fp_mul u_py (.clk (clk), .en (en), .a (xyz_d[63:32]), .b (inv_w), .y (py));
  vtu_fp_mul u_pz (.clk (clk), .en (en), .a (xyz_d[31:0]),  .b (inv_w), .y (pz));

  vtu_fp_mul u_tx (.clk (clk), .en (en), .a (view.hw), .b (px), .y (tx));
  vtu_fp_mul u_ty (.clk (clk), .en (en), .a (view.hh), .b ({~py[31], py[30:0]}), .y (ty));
  vtu_fp_mul u_tz (.clk (clk), .en (en), .a (view.hd), .b (pz), .y (tz));

  vtu_fp_add u_sx (.clk (clk), .en (en), .a (tx), .b (view.ox),   .y (res.screen_x));
  vtu_fp_add u_sy (.clk (clk), .en (en), .a (ty), .b (view.oy),   .y (res.screen_y));
  vtu_fp_add u_sz (.clk (clk), .en (en), .a (tz), .b (view.zmin), .y (res.screen_depth));

  assign res.recip_w = inv_w_d;

  vtu_out_buf u_obuf (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (vld_last),
    .in_data  (res),
    .in_rdy   (en),
    .out_vld  (out_scr.valid),
    .out_rdy  (out_scr.ready),
    .out_data (res_out)
  );

  assign out_scr.screen_x     = res_out.screen_x;
  assign out_scr.screen_y     = res_out.screen_y;
  assign out_scr.screen_depth = res_out.screen_depth;
  assign out_scr.recip_w      = res_out.recip_w;

endmodule

// File: hw/rtl/vtu_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Viewport transform unit checker
// Port-level assertions on the channels, bound to the top level.
// ----------------------------------------------------------------------------
module vtu_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] screen_x,
  input logic [31:0] screen_y,
  input logic [31:0] screen_depth,
  input logic [31:0] recip_w
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(screen_x) && $stable(screen_y) &&
                                $stable(screen_depth) && $stable(recip_w))
    else $error("Stalled result word changed or was dropped");

  a_full_valid: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("Input held off while no result is waiting");

  a_nan_canon: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (screen_x == 32'h7FC0_0000 || screen_x[30:23] != 8'hFF ||
                   screen_x[22:0] == 23'd0) &&
                  (screen_y == 32'h7FC0_0000 || screen_y[30:23] != 8'hFF ||
                   screen_y[22:0] == 23'd0) &&
                  (screen_depth == 32'h7FC0_0000 || screen_depth[30:23] != 8'hFF ||
                   screen_depth[22:0] == 23'd0) &&
                  (recip_w == 32'h7FC0_0000 || recip_w[30:23] != 8'hFF ||
                   recip_w[22:0] == 23'd0))
    else $error("Result NaN is not the canonical quiet NaN");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("Result word shown straight after reset");

endmodule

bind viewport_transform_unit_top vtu_checker u_vtu_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_ready     (in_vtx.ready),
  .out_valid    (out_scr.valid),
  .out_ready    (out_scr.ready),
  .screen_x     (out_scr.screen_x),
  .screen_y     (out_scr.screen_y),
  .screen_depth (out_scr.screen_depth),
  .recip_w      (out_scr.recip_w)
);

// File: test/viewport_transform_unit_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Viewport transform unit testbench
// Streams clip-space vertices through the unit under several viewport and
// depth settings and compares every screen-space word with an independent
// single-precision model. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module viewport_transform_unit_top_tb;
  import vtu_pkg::*;

  localparam logic [2:0] REG_UNMAPPED = 3'd6;
  localparam int         CYCLE_LIMIT  = 600000;

  class viewport_checker;
    vtu_result_t expected_screen[$];
    logic [14:0] left, top, width, height;
    logic [31:0] zmin, zmax;
    int          failures;

    function new();
      left = '0; top = '0; width = '0; height = '0;
      zmin = FP_ZERO; zmax = FP_ONE; failures = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [31:0] v);
      case (idx)
        REG_VIEW_LEFT:   left   = v[14:0];
        REG_VIEW_TOP:    top    = v[14:0];
        REG_VIEW_WIDTH:  width  = v[14:0];
        REG_VIEW_HEIGHT: height = v[14:0];
        REG_DEPTH_MIN:   zmin   = v;
        REG_DEPTH_MAX:   zmax   = v;
        default: ;
      endcase
    endfunction

    function real as_real(logic [31:0] b);
      logic [22:0] m;
      int          e;
      if (b[30:23] == 8'hFF) begin
        if (b[22:0] != 0) return $bitstoreal(64'h7FF8_0000_0000_0000);
        return $bitstoreal({b[31], 11'h7FF, 52'd0});
      end
      if (b[30:0] == 0) return $bitstoreal({b[31], 63'd0});
      m = b[22:0];
      if (b[30:23] != 0) begin
        e = int'(b[30:23]) - 127;
      end else begin
        e = -126;
        while (!m[22]) begin
          m = m << 1;
          e--;
        end
        e--;
        m = {m[21:0], 1'b0};
      end
      return $bitstoreal({b[31], 11'(e + 1023), m, 29'd0});
    endfunction

    // Correct rounding of a double to single precision, nearest even.
    function logic [31:0] to_single(real r);
      logic [63:0] d;
      logic [63:0] mant;
      logic [63:0] kept;
      int          e;
      int          sh;
      logic        half;
      logic        sticky;
      d = $realtobits(r);
      if (d[62:52] == 11'h7FF) return (d[51:0] != 0) ? FP_QNAN : {d[63], 8'hFF, 23'd0};
      if (d[62:52] == 0) return {d[63], 31'd0};
      e = int'(d[62:52]) - 1023;
      mant = {11'd0, 1'b1, d[51:0]};
      sh = (e >= -126) ? 29 : 29 + (-126 - e);
      if (sh > 53) return {d[63], 31'd0};
      kept = mant >> sh;
      half = mant[sh-1];
      sticky = |(mant & ((64'd1 << (sh - 1)) - 64'd1));
      if (half && (sticky || kept[0])) kept = kept + 1;
      if (e >= -126) begin
        if (kept[24]) begin
          kept = kept >> 1;
          e++;
        end
        if (e > 127) return {d[63], 8'hFF, 23'd0};
        return {d[63], 8'(e + 127), kept[22:0]};
      end
      return {d[63], kept[30:0]};
    endfunction

    function logic [31:0] fmul(logic [31:0] a, logic [31:0] b);
      return to_single(as_real(a) * as_real(b));
    endfunction

    function logic [31:0] fadd(logic [31:0] a, logic [31:0] b);
      return to_single(as_real(a) + as_real(b));
    endfunction

    function void note_vertex(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                              logic [31:0] w);
      vtu_result_t r;
      logic [31:0] inv, hw, hh, hd, ox, oy, py;
      inv = (w[30:0] == 0) ? FP_ONE : to_single(1.0 / as_real(w));
      hw = fmul(to_single(real'(width)), FP_HALF);
      hh = fmul(to_single(real'(height)), FP_HALF);
      ox = fmul(to_single(real'(int'(left) + int'(width))), FP_HALF);
      oy = fmul(to_single(real'(int'(top) + int'(height))), FP_HALF);
      hd = fmul(to_single(as_real(zmax) - as_real(zmin)), FP_HALF);
      py = fmul(y, inv);
      r.screen_x = fadd(fmul(hw, fmul(x, inv)), ox);
      r.screen_y = fadd(fmul(hh, {~py[31], py[30:0]}), oy);
      r.screen_depth = fadd(fmul(hd, fmul(z, inv)), zmin);
      r.recip_w = to_single(as_real(inv));
      expected_screen.push_back(r);
    endfunction

    function void check_screen(vtu_result_t got);
      vtu_result_t exp_r;
      if (expected_screen.size() == 0) begin
        $error("screen word arrived with nothing outstanding");
        failures++;
        return;
      end
      exp_r = expected_screen.pop_front();
      if (got.screen_x !== exp_r.screen_x) begin
        $error("screen_x: expected %h, got %h", exp_r.screen_x, got.screen_x);
        failures++;
      end
      if (got.screen_y !== exp_r.screen_y) begin
        $error("screen_y: expected %h, got %h", exp_r.screen_y, got.screen_y);
        failures++;
      end
      if (got.screen_depth !== exp_r.screen_depth) begin
        $error("screen_depth: expected %h, got %h", exp_r.screen_depth, got.screen_depth);
        failures++;
      end
      if (got.recip_w !== exp_r.recip_w) begin
        $error("recip_w: expected %h, got %h", exp_r.recip_w, got.recip_w);
        failures++;
      end
    endfunction
  endclass

  logic              clk;
  logic              rst_n;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [CFG_AW-1:0] paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;

  vtu_vertex_if vin ();
  vtu_screen_if vout ();

  viewport_transform_unit_top dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vtx  (vin),
    .out_scr (vout),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  viewport_checker checker_h = new();
  int burst_left = 0;
  int cycles = 0;
  int stall_mode = 0;
  int stall_count = 0;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      vout.ready <= 1'b0;
    end else begin
      stall_count <= stall_count + 1;
      if (stall_count % 150 == 0) stall_mode <= $urandom_range(0, 3);
      case (stall_mode)
        0: vout.ready <= 1'b1;
        1: vout.ready <= $urandom_range(0, 1);
        2: vout.ready <= (stall_count % 4 == 0);
        default: vout.ready <= (stall_count % 40 >= 25);
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst_n && vout.valid && vout.ready) begin
      checker_h.check_screen({vout.screen_x, vout.screen_y, vout.screen_depth, vout.recip_w});
    end
  end

  function automatic logic [31:0] pick_fp();
    logic [31:0] specials[12] = '{32'h0000_0000, 32'h8000_0000, 32'h7F80_0000,
                                  32'hFF80_0000, 32'h7FC0_0000, 32'h7F80_0001,
                                  32'h0000_0001, 32'h807F_FFFF, 32'h7F7F_FFFF,
                                  32'h3F80_0000, 32'h0080_0000, 32'hFFFF_FFFF};
    case ($urandom_range(0, 9))
      0: return specials[$urandom_range(0, 11)];
      1, 2: return $urandom;
      default: return {1'($urandom), 8'($urandom_range(118, 136)), 23'($urandom)};
    endcase
  endfunction

  task automatic send_vertex(input logic [31:0] x, input logic [31:0] y,
                             input logic [31:0] z, input logic [31:0] w);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        vin.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    vin.valid <= 1'b1;
    vin.clip_x <= x;
    vin.clip_y <= y;
    vin.clip_z <= z;
    vin.clip_w <= w;
    do @(posedge clk); while (!vin.ready);
    checker_h.note_vertex(x, y, z, w);
    burst_left--;
  endtask

  task automatic drain();
    vin.valid <= 1'b0;
    burst_left = 0;
    while (checker_h.expected_screen.size() != 0) @(posedge clk);
    repeat (TOTAL_LAT + 4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    checker_h.set_reg(idx, v);
  endtask

  task automatic set_view(input logic [31:0] l, input logic [31:0] t, input logic [31:0] wd,
                          input logic [31:0] ht, input logic [31:0] dmin,
                          input logic [31:0] dmax);
    drain();
    write_reg(REG_VIEW_LEFT, l);
    write_reg(REG_VIEW_TOP, t);
    write_reg(REG_VIEW_WIDTH, wd);
    write_reg(REG_VIEW_HEIGHT, ht);
    write_reg(REG_DEPTH_MIN, dmin);
    write_reg(REG_DEPTH_MAX, dmax);
  endtask

  task automatic random_vertices(input int n);
    logic [31:0] w;
    repeat (n) begin
      w = pick_fp();
      if ($urandom_range(0, 19) == 0) w = {1'($urandom), 31'd0};
      send_vertex(pick_fp(), pick_fp(), pick_fp(), w);
    end
  endtask

  initial begin
    rst_n = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    vin.valid = 1'b0;
    vin.clip_x = '0;
    vin.clip_y = '0;
    vin.clip_z = '0;
    vin.clip_w = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_vertex(32'h3F00_0000, 32'hBF00_0000, 32'h3E80_0000, 32'h3F80_0000);
    send_vertex(32'h3F80_0000, 32'h3F80_0000, 32'h3F80_0000, 32'h0000_0000);
    send_vertex(32'h3F80_0000, 32'h3F80_0000, 32'h3F80_0000, 32'h8000_0000);
    set_view(32'd0, 32'd0, 32'd1920, 32'd1080, 32'h0000_0000, FP_ONE);
    send_vertex(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h4000_0000);
    send_vertex(32'h7F80_0000, 32'hFF80_0000, 32'h7FC0_0000, 32'h3F80_0000);
    send_vertex(32'h3F80_0000, 32'h3F80_0000, 32'h3F80_0000, 32'h7F80_0000);
    send_vertex(32'h7F7F_FFFF, 32'hFF7F_FFFF, 32'h7F7F_FFFF, 32'h0000_0001);
    send_vertex(32'h0000_0001, 32'h8000_0001, 32'h007F_FFFF, 32'h7F7F_FFFF);
    send_vertex(32'hFFFF_FFFF, 32'h7F80_0001, 32'h0080_0000, 32'hFF80_0000);
    send_vertex(32'h3F80_0000, 32'hBF80_0000, 32'h4000_0000, 32'h7FC0_0000);
    send_vertex(32'hC2C8_0000, 32'h42C8_0000, 32'h3F00_0000, 32'hC0A0_0000);
    set_view(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
             32'hFF7F_FFFF, 32'h7F7F_FFFF);
    send_vertex(32'h3F80_0000, 32'hBF80_0000, 32'h3F80_0000, 32'h3F80_0000);
    send_vertex(32'hBF80_0000, 32'h3F80_0000, 32'hBF80_0000, 32'h3F80_0000);
    send_vertex(32'h0000_0000, 32'h8000_0000, 32'h0000_0000, 32'h8000_0000);
    random_vertices(130);

    set_view(32'd16384, 32'd16383, 32'd16384, 32'd1, 32'h7F80_0000, 32'hFF80_0000);
    random_vertices(150);
    set_view(32'd100, 32'd50, 32'd640, 32'd480, 32'h3DCC_CCCD, 32'h3F80_0000);
    random_vertices(150);
    set_view($urandom, $urandom, $urandom, $urandom, pick_fp(), pick_fp());
    random_vertices(150);
    set_view($urandom, $urandom, $urandom, $urandom, 32'h7FC0_0001, 32'h0000_0001);
    random_vertices(100);
    drain();
    write_reg(REG_UNMAPPED, 32'hFFFF_FFFF);
    write_reg(REG_DEPTH_MIN, 32'h0000_0000);
    write_reg(REG_DEPTH_MAX, 32'h3F80_0000);
    random_vertices(100);
    set_view(32'd0, 32'd0, 32'd0, 32'd0, 32'h8000_0000, 32'h0000_0000);
    random_vertices(100);

    drain();
    if (checker_h.failures == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/vtu_pkg.sv
hw/rtl/vtu_if.sv
hw/rtl/vtu_delay.sv
hw/rtl/vtu_fp_mul.sv
hw/rtl/vtu_fp_add.sv
hw/rtl/vtu_recip.sv
hw/rtl/vtu_cfg.sv
hw/rtl/vtu_out_buf.sv
hw/rtl/viewport_transform_unit_top.sv
hw/rtl/vtu_checker.sv
test/viewport_transform_unit_top_tb.sv
